@@ sv/sto_pkg.sv @@
// sto_pkg: shared widths, reset values, register indexes and control structs
// for the silence timeout detector. no dependencies.
`default_nettype none

package sto_pkg;

  localparam int MAX_CHUNK_SAMPLES_DEF = 4096;

  localparam int SAMPLE_W = 16;
  localparam int MAG_W    = 15;
  localparam int RATE_W   = 18;
  localparam int CHAN_W   = 4;
  localparam int TMO_W    = 16;
  localparam int QUIET_W  = 15;
  localparam int ACC_W    = 17;

  localparam int APB_AW = 4;
  localparam int APB_DW = 32;

  localparam int MS_PER_S = 1000;

  localparam logic [RATE_W-1:0]  RATE_DEFAULT  = RATE_W'(16000);
  localparam logic [CHAN_W-1:0]  CHAN_DEFAULT  = CHAN_W'(1);
  localparam logic [TMO_W-1:0]   TMO_DEFAULT   = TMO_W'(1200);
  localparam logic [QUIET_W-1:0] QUIET_DEFAULT = QUIET_W'(500);

  typedef enum logic [1:0] {
    REG_RATE  = 2'd0,
    REG_CHAN  = 2'd1,
    REG_TMO   = 2'd2,
    REG_QUIET = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

@@ sv/sto_divider.sv @@
// sto_divider: restoring divider, one quotient bit per cycle.
// dividend is left aligned, steps gives the quotient bits. uses sto_pkg.
`default_nettype none

module sto_divider #(
  parameter int DW = 23,
  parameter int VW = 18
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire sto_pkg::div_ctrl_t        ctrl,
  input  wire logic [DW-1:0]             dividend,
  input  wire logic [VW-1:0]             divisor,
  input  wire logic [$clog2(DW+1)-1:0]   steps,
  output sto_pkg::div_stat_t             stat,
  output logic [DW-1:0]                  quotient
);
  import sto_pkg::*;

  localparam int SW = $clog2(DW + 1);

  logic [VW-1:0] rem_r;
  logic [DW-1:0] quo_r;
  logic [VW-1:0] dvs_r;
  logic [SW-1:0] cnt_r;
  logic          done_r;

  logic [VW:0]   trial;
  logic          ge;
  logic [VW-1:0] rem_nxt;

  always_comb begin
    trial   = {rem_r, quo_r[DW-1]};
    ge      = trial >= {1'b0, dvs_r};
    rem_nxt = ge ? VW'(trial - {1'b0, dvs_r}) : trial[VW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (ctrl.start) begin
        cnt_r <= steps;
        rem_r <= '0;
        quo_r <= dividend;
        dvs_r <= divisor;
      end else if (cnt_r != '0) begin
        rem_r <= rem_nxt;
        quo_r <= {quo_r[DW-2:0], ge};
        cnt_r <= cnt_r - SW'(1);
        if (cnt_r == SW'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = (cnt_r != '0);
  assign stat.done = done_r;
  assign quotient  = quo_r;

endmodule

`default_nettype wire

@@ sv/silence_timeout_detector.sv @@
// silence_timeout_detector: chunk peak and sample count, chunk duration in ms,
// silence accumulator with timeout. uses sto_pkg and sto_divider.
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+-----------------------
//  input   | in_sample, in_chunk_end, in_uploading   | in_valid / in_stall
//  result  | out_timeout_hit, out_chunk_silent,      | out_valid / out_stall
//          | out_silence_total_ms                    |
//  config  | psel penable pwrite paddr pwdata prdata | pready always high
//
// an item that does not end a chunk is taken back to back while in_stall is low.
// a chunk-end item runs two divisions on the shared serial divider, one bit
// a cycle: in_stall stays high from the accept through both divisions until
// the result is loaded into the output register.
// a result waiting in the output register does not stop new samples; the next
// chunk end then waits after its divisions until that result is taken.
// rst_n is synchronous; it clears chunk state and the accumulator and returns config to its defaults.
`default_nettype none

module silence_timeout_detector #(
  parameter int MAX_CHUNK_SAMPLES = sto_pkg::MAX_CHUNK_SAMPLES_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic signed [sto_pkg::SAMPLE_W-1:0] in_sample,
  input  wire logic                           in_chunk_end,
  input  wire logic                           in_uploading,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic                                out_timeout_hit,
  output logic                                out_chunk_silent,
  output logic [sto_pkg::ACC_W-1:0]           out_silence_total_ms,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [sto_pkg::APB_AW-1:0]     paddr,
  input  wire logic [sto_pkg::APB_DW-1:0]     pwdata,
  output logic [sto_pkg::APB_DW-1:0]          prdata,
  output logic                                pready
);
  import sto_pkg::*;

  localparam int CNTW  = (MAX_CHUNK_SAMPLES > 1) ? $clog2(MAX_CHUNK_SAMPLES) : 1;
  localparam int TOTW  = $clog2(MAX_CHUNK_SAMPLES + 1);
  localparam int PRODW = $clog2(MAX_CHUNK_SAMPLES * MS_PER_S + 1);
  localparam int SUMW  = ((PRODW > ACC_W) ? PRODW : ACC_W) + 1;
  localparam int DSW   = $clog2(PRODW + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV1,
    S_MUL,
    S_DIV2,
    S_POST
  } state_t;

  // configuration
  logic [RATE_W-1:0]  rate_r;
  logic [CHAN_W-1:0]  chan_r;
  logic [TMO_W-1:0]   tmo_r;
  logic [QUIET_W-1:0] quiet_r;
  reg_idx_t           reg_idx;
  logic               cfg_wr;

  assign reg_idx = reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r  <= RATE_DEFAULT;
      chan_r  <= CHAN_DEFAULT;
      tmo_r   <= TMO_DEFAULT;
      quiet_r <= QUIET_DEFAULT;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_RATE:  rate_r  <= pwdata[RATE_W-1:0];
        REG_CHAN:  chan_r  <= pwdata[CHAN_W-1:0];
        REG_TMO:   tmo_r   <= pwdata[TMO_W-1:0];
        REG_QUIET: quiet_r <= pwdata[QUIET_W-1:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_RATE:  prdata = APB_DW'(rate_r);
      REG_CHAN:  prdata = APB_DW'(chan_r);
      REG_TMO:   prdata = APB_DW'(tmo_r);
      REG_QUIET: prdata = APB_DW'(quiet_r);
      default:   prdata = '0;
    endcase
  end

  // datapath
  state_t             state_r;
  logic [MAG_W-1:0]   peak_r;
  logic [CNTW-1:0]    cnt_r;
  logic [ACC_W-1:0]   acc_r;
  logic               silent_r;
  logic               active_r;
  logic [PRODW-1:0]   prod_r;
  logic [PRODW-1:0]   dur_r;
  logic               out_valid_r;
  logic               out_hit_r;
  logic               out_silent_r;
  logic [ACC_W-1:0]   out_total_r;

  div_ctrl_t          div_ctrl_r;
  logic [PRODW-1:0]   div_dvd_r;
  logic [RATE_W-1:0]  div_dvs_r;
  logic [DSW-1:0]     div_steps_r;
  div_stat_t          div_st;
  logic [PRODW-1:0]   div_quo;

  logic [SAMPLE_W-1:0] neg;
  logic [MAG_W-1:0]   mag;
  logic [MAG_W-1:0]   peak_new;
  logic [TOTW-1:0]    total;
  logic [TOTW-1:0]    frames;
  logic [RATE_W-1:0]  rate_eff;
  logic [CHAN_W-1:0]  chan_eff;
  logic [SUMW-1:0]    acc_sum;
  logic               hit;
  logic               accept;
  logic               out_free;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    neg = SAMPLE_W'(~in_sample + SAMPLE_W'(1));
    if (!in_sample[SAMPLE_W-1]) begin
      mag = in_sample[MAG_W-1:0];
    end else if (neg[SAMPLE_W-1]) begin
      // most negative sample saturates
      mag = '1;
    end else begin
      mag = neg[MAG_W-1:0];
    end
    peak_new = (peak_r > mag) ? peak_r : mag;
    total    = TOTW'(cnt_r) + TOTW'(1);
    frames   = div_quo[TOTW-1:0];
    rate_eff = (rate_r == '0) ? RATE_DEFAULT : rate_r;
    chan_eff = (chan_r == '0) ? CHAN_DEFAULT : chan_r;
    acc_sum  = SUMW'(acc_r) + SUMW'(dur_r);
    hit      = (acc_sum >= SUMW'(tmo_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      peak_r      <= '0;
      cnt_r       <= '0;
      acc_r       <= '0;
      div_ctrl_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      div_ctrl_r.start <= (state_r == S_MUL) || (accept && in_chunk_end);
      if ((state_r == S_POST) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (!in_chunk_end) begin
              peak_r <= peak_new;
              if (cnt_r < CNTW'(MAX_CHUNK_SAMPLES - 1)) begin
                cnt_r <= cnt_r + CNTW'(1);
              end
            end else begin
              silent_r         <= (peak_new <= quiet_r);
              active_r         <= in_uploading;
              peak_r           <= '0;
              cnt_r            <= '0;
              div_dvd_r        <= {total, {(PRODW-TOTW){1'b0}}};
              div_dvs_r        <= RATE_W'(chan_eff);
              div_steps_r      <= DSW'(TOTW);
              state_r          <= S_DIV1;
            end
          end
        end
        S_DIV1: begin
          if (div_st.done) begin
            prod_r  <= PRODW'({{(PRODW-TOTW){1'b0}}, frames} * PRODW'(MS_PER_S));
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          div_dvd_r        <= prod_r;
          div_dvs_r        <= rate_eff;
          div_steps_r      <= DSW'(PRODW);
          state_r          <= S_DIV2;
        end
        S_DIV2: begin
          if (div_st.done) begin
            dur_r   <= div_quo;
            state_r <= S_POST;
          end
        end
        S_POST: begin
          if (out_free) begin
            out_silent_r <= silent_r;
            if (active_r && (tmo_r != '0) && silent_r) begin
              out_hit_r   <= hit;
              out_total_r <= hit ? '0 : acc_sum[ACC_W-1:0];
              acc_r       <= hit ? '0 : acc_sum[ACC_W-1:0];
            end else begin
              out_hit_r   <= 1'b0;
              out_total_r <= '0;
              acc_r       <= '0;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  sto_divider #(
    .DW (PRODW),
    .VW (RATE_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (div_ctrl_r),
    .dividend (div_dvd_r),
    .divisor  (div_dvs_r),
    .steps    (div_steps_r),
    .stat     (div_st),
    .quotient (div_quo)
  );

  assign out_valid            = out_valid_r;
  assign out_timeout_hit      = out_hit_r;
  assign out_chunk_silent     = out_silent_r;
  assign out_silence_total_ms = out_total_r;

  // checks
  a_result_from_post: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_POST))
    else $error("result raised outside post state");

  a_hit_clears_acc: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_hit_r) |-> (out_total_r == '0 && acc_r == '0))
    else $error("timeout item with nonzero accumulator");

  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_POST) |-> !div_st.busy)
    else $error("divider busy while sequencer idle");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNTW'(MAX_CHUNK_SAMPLES - 1))
    else $error("sample count beyond saturation");

endmodule

`default_nettype wire
